### rtl/rpc_pkg.sv
`timescale 1ns / 1ps

package rpc_pkg;

  // Field widths fixed by the interface
  localparam int ID_W      = 7;
  localparam int LEVEL_W   = 4;
  localparam int VERDICT_W = 2;
  localparam int CMD_W     = 2;

  // Ids are ID_W bits wide, so no table needs more rows than this
  localparam int ID_SPAN = 1 << ID_W;

  // Highest level; larger inputs saturate to it
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd9;

  // Parameter defaults
  localparam int MAX_PRIVS_DEF      = 128;
  localparam int MAX_ROLES_DEF      = 128;
  localparam int MAX_USERS_DEF      = 128;
  localparam int ROLES_PER_USER_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_DECLARE  = 2'd0,
    CMD_GRANT    = 2'd1,
    CMD_ADD_ROLE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  // Also used as the running best answer of a query
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FALSE = 2'd0,
    VERDICT_TRUE  = 2'd1,
    VERDICT_LEVEL = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_Q_RUN,
    ST_Q_DONE
  } state_e;

  // One grant table entry
  typedef struct packed {
    logic               granted;
    logic               unleveled;
    logic [LEVEL_W-1:0] level;
  } grant_t;

endpackage

### rtl/rpc_grant_mem.sv
`timescale 1ns / 1ps

// Grant table: one write port, one registered read port, and a clearing
// sweep after reset that writes every entry as not granted.
module rpc_grant_mem #(
  parameter int AW = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output rpc_pkg::grant_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  rpc_pkg::grant_t wr_data_i,
  output logic            busy_o
);

  localparam int DEPTH = 1 << AW;

  rpc_pkg::grant_t grant_mem [DEPTH];
  rpc_pkg::grant_t rd_data_q;

  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic            we;
  logic [AW-1:0]   waddr;
  rpc_pkg::grant_t wdata;

  // Sweep counter
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {AW{1'b1}}) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port shared by the sweep and the user
  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      grant_mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= grant_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

### rtl/role_permission_check.sv
`timescale 1ns / 1ps

// Role-based permission checker.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// declare a privilege, grant a privilege to a role, add a role to a user, or
// query a user for a privilege. Only a query produces a result transaction on
// the output channel (out_valid_o / out_stall_i): verdict_o and level_out_o.
// One command is in flight at a time. A declare is written on accept. Grant and
// add-role read their table entries in the accept cycle and write back in the
// next one. A query reads its privilege flags and role count on accept, then
// walks the role list one role per cycle through a two-stage list and grant
// read pipeline and loads the result; an early match ends the walk, and a query
// with no roles to walk goes straight to loading the result.
// Reset holds in_stall_o high while the privilege flags and role counts are
// cleared and a sweep writes the whole grant table (2**(ROLE_AW + PRIV_AW)
// entries, 16384 with default parameters) as not granted, one entry per cycle.
// The result sits in an output register; while the receiver stalls, commands
// that give no result are still taken, and a following query holds its answer
// until the register frees.
module role_permission_check #(
  parameter int MAX_PRIVS      = rpc_pkg::MAX_PRIVS_DEF,
  parameter int MAX_ROLES      = rpc_pkg::MAX_ROLES_DEF,
  parameter int MAX_USERS      = rpc_pkg::MAX_USERS_DEF,
  parameter int ROLES_PER_USER = rpc_pkg::ROLES_PER_USER_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rpc_pkg::CMD_W-1:0]     cmd_i,
  input  logic [rpc_pkg::ID_W-1:0]      user_id_i,
  input  logic [rpc_pkg::ID_W-1:0]      role_id_i,
  input  logic [rpc_pkg::ID_W-1:0]      priv_id_i,
  input  logic [rpc_pkg::LEVEL_W-1:0]   level_i,
  input  logic                          has_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rpc_pkg::VERDICT_W-1:0] verdict_o,
  output logic [rpc_pkg::LEVEL_W-1:0]   level_out_o
);

  // Ids never exceed ID_SPAN, so tables stop there
  localparam int PRIV_DEPTH = (MAX_PRIVS < rpc_pkg::ID_SPAN) ? MAX_PRIVS : rpc_pkg::ID_SPAN;
  localparam int ROLE_DEPTH = (MAX_ROLES < rpc_pkg::ID_SPAN) ? MAX_ROLES : rpc_pkg::ID_SPAN;
  localparam int USER_DEPTH = (MAX_USERS < rpc_pkg::ID_SPAN) ? MAX_USERS : rpc_pkg::ID_SPAN;
  localparam int PRIV_AW    = $clog2(PRIV_DEPTH);
  localparam int ROLE_AW    = $clog2(ROLE_DEPTH);
  localparam int USER_AW    = $clog2(USER_DEPTH);
  localparam int RPU_AW     = (ROLES_PER_USER > 1) ? $clog2(ROLES_PER_USER) : 1;
  localparam int CNT_W      = $clog2(ROLES_PER_USER + 1);
  localparam int GRANT_AW   = ROLE_AW + PRIV_AW;
  localparam int LIST_AW    = USER_AW + RPU_AW;
  localparam int LIST_DEPTH = 1 << LIST_AW;
  localparam int PRIV_MEM_DEPTH = 1 << PRIV_AW;
  localparam int USER_MEM_DEPTH = 1 << USER_AW;

  rpc_pkg::state_e state_q, state_d;

  // Clear counter for the flag and count memories
  logic [rpc_pkg::ID_W-1:0] clr_q, clr_d;
  logic                     clr_done;
  logic                     clearing;

  // Privilege flags memory: bit 1 declared, bit 0 leveled
  logic [1:0]         priv_mem [PRIV_MEM_DEPTH];
  logic [1:0]         priv_rdata_q;
  logic               priv_we;
  logic [PRIV_AW-1:0] priv_waddr;
  logic [1:0]         priv_wdata;
  logic               p_decl, p_lev;

  // Role count memory
  logic [CNT_W-1:0]   cnt_mem [USER_MEM_DEPTH];
  logic [CNT_W-1:0]   cnt_rdata_q;
  logic               cnt_we;
  logic [USER_AW-1:0] cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;

  // Role list memory
  logic [ROLE_AW-1:0] list_mem [LIST_DEPTH];
  logic [ROLE_AW-1:0] list_rdata_q;
  logic               list_re;
  logic [LIST_AW-1:0] list_raddr;

  // Captured command
  rpc_pkg::cmd_e               cmd_q;
  logic [USER_AW-1:0]          ua_q;
  logic [ROLE_AW-1:0]          ra_q;
  logic [PRIV_AW-1:0]          pa_q;
  logic [rpc_pkg::LEVEL_W-1:0] lvl_q;
  logic                        has_lvl_q;
  logic                        uid_ok_q, rid_ok_q, pid_ok_q;

  // Query scan
  logic [CNT_W-1:0]            k_q, k_d;
  logic                        lv_q, lv_d;
  logic                        gv_q, gv_d;
  rpc_pkg::verdict_e           best_q, best_d;
  logic [rpc_pkg::LEVEL_W-1:0] best_lvl_q, best_lvl_d;

  // Output register
  logic                          out_valid_q;
  logic [rpc_pkg::VERDICT_W-1:0] verdict_q;
  logic [rpc_pkg::LEVEL_W-1:0]   lvl_out_q;
  logic                          out_load;

  // Grant table port
  logic                g_rd_en, g_wr_en, g_busy;
  logic [GRANT_AW-1:0] g_rd_addr, g_wr_addr;
  rpc_pkg::grant_t     g_rd_data, g_wr_data;

  // Input decode
  logic                        in_acc;
  logic                        uid_ok, rid_ok, pid_ok;
  logic [USER_AW-1:0]          ua;
  logic [ROLE_AW-1:0]          ra;
  logic [PRIV_AW-1:0]          pa;
  logic                        u_room;
  logic [rpc_pkg::LEVEL_W-1:0] lvl_c;
  logic                        decl_we;
  logic                        add_we;

  assign in_stall_o = (state_q != rpc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign uid_ok  = 32'(user_id_i) < MAX_USERS;
  assign rid_ok  = 32'(role_id_i) < MAX_ROLES;
  assign pid_ok  = 32'(priv_id_i) < MAX_PRIVS;
  assign ua      = user_id_i[USER_AW-1:0];
  assign ra      = role_id_i[ROLE_AW-1:0];
  assign pa      = priv_id_i[PRIV_AW-1:0];
  assign lvl_c   = (level_i > rpc_pkg::LEVEL_MAX) ? rpc_pkg::LEVEL_MAX : level_i;
  assign decl_we = in_acc && (cmd_i == rpc_pkg::CMD_DECLARE) && pid_ok;

  // Looked-up entries of the command in flight
  assign p_decl = priv_rdata_q[1];
  assign p_lev  = priv_rdata_q[0];
  assign u_room = 32'(cnt_rdata_q) < ROLES_PER_USER;
  assign add_we = (state_q == rpc_pkg::ST_LOOKUP) && (cmd_q == rpc_pkg::CMD_ADD_ROLE) &&
                  uid_ok_q && rid_ok_q && u_room;

  // Clear counter stops at its last entry
  assign clearing = (state_q == rpc_pkg::ST_CLEAR);
  assign clr_done = (clr_q == '1);
  assign clr_d    = clr_done ? clr_q : clr_q + 1'b1;

  // Privilege flags: cleared after reset, written on declare, read on accept
  assign priv_we    = clearing | decl_we;
  assign priv_waddr = clearing ? clr_q[PRIV_AW-1:0] : pa;
  assign priv_wdata = clearing ? 2'b00 : {1'b1, has_level_i};

  always_ff @(posedge clk_i) begin
    if (priv_we) begin
      priv_mem[priv_waddr] <= priv_wdata;
    end
    if (in_acc) begin
      priv_rdata_q <= priv_mem[pa];
    end
  end

  // Role counts: cleared after reset, bumped on add-role, read on accept
  assign cnt_we    = clearing | add_we;
  assign cnt_waddr = clearing ? clr_q[USER_AW-1:0] : ua_q;
  assign cnt_wdata = clearing ? '0 : cnt_rdata_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (in_acc) begin
      cnt_rdata_q <= cnt_mem[ua];
    end
  end

  // Role list memory: append on add-role, read during a query scan
  assign list_raddr = {ua_q, k_q[RPU_AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      list_mem[{ua_q, cnt_rdata_q[RPU_AW-1:0]}] <= ra_q;
    end
    if (list_re) begin
      list_rdata_q <= list_mem[list_raddr];
    end
  end

  // Capture the command fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q     <= rpc_pkg::cmd_e'(cmd_i);
      ua_q      <= ua;
      ra_q      <= ra;
      pa_q      <= pa;
      lvl_q     <= lvl_c;
      has_lvl_q <= has_level_i;
      uid_ok_q  <= uid_ok;
      rid_ok_q  <= rid_ok;
      pid_ok_q  <= pid_ok;
    end
  end

  rpc_grant_mem #(
    .AW (GRANT_AW)
  ) u_grant_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (g_rd_en),
    .rd_addr_i (g_rd_addr),
    .rd_data_o (g_rd_data),
    .wr_en_i   (g_wr_en),
    .wr_addr_i (g_wr_addr),
    .wr_data_i (g_wr_data),
    .busy_o    (g_busy)
  );

  // Sequencer: next state, memory controls, query scan
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    lv_d       = 1'b0;
    gv_d       = 1'b0;
    best_d     = best_q;
    best_lvl_d = best_lvl_q;
    list_re    = 1'b0;
    g_rd_en    = 1'b0;
    g_rd_addr  = {ra, pa};
    g_wr_en    = 1'b0;
    g_wr_addr  = {ra_q, pa_q};
    g_wr_data  = '0;
    out_load   = 1'b0;

    case (state_q)
      rpc_pkg::ST_CLEAR: begin
        if (!g_busy && clr_done) begin
          state_d = rpc_pkg::ST_IDLE;
        end
      end

      // Declare finishes here; everything else looks up its entries first
      rpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i != rpc_pkg::CMD_DECLARE) begin
            state_d = rpc_pkg::ST_LOOKUP;
          end
          if (cmd_i == rpc_pkg::CMD_GRANT) begin
            g_rd_en = 1'b1;
          end
        end
      end

      rpc_pkg::ST_LOOKUP: begin
        state_d = rpc_pkg::ST_IDLE;
        case (cmd_q)
          // Grant merge: unleveled overwrites, leveled replaces an unleveled grant and otherwise keeps the higher level
          rpc_pkg::CMD_GRANT: begin
            if (rid_ok_q && pid_ok_q && p_decl) begin
              if (!has_lvl_q) begin
                g_wr_en   = 1'b1;
                g_wr_data = '{granted: 1'b1, unleveled: 1'b1, level: '0};
              end else if (!g_rd_data.granted || g_rd_data.unleveled ||
                           (lvl_q > g_rd_data.level)) begin
                g_wr_en   = 1'b1;
                g_wr_data = '{granted: 1'b1, unleveled: 1'b0, level: lvl_q};
              end
            end
          end
          rpc_pkg::CMD_QUERY: begin
            best_d     = rpc_pkg::VERDICT_FALSE;
            best_lvl_d = '0;
            k_d        = '0;
            if (uid_ok_q && pid_ok_q && p_decl && (cnt_rdata_q != '0)) begin
              state_d = rpc_pkg::ST_Q_RUN;
            end else begin
              state_d = rpc_pkg::ST_Q_DONE;
            end
          end
          default: begin
          end
        endcase
      end

      // Scan: list read, then grant read, then evaluate
      rpc_pkg::ST_Q_RUN: begin
        if (k_q < cnt_rdata_q) begin
          list_re = 1'b1;
          k_d     = k_q + 1'b1;
          lv_d    = 1'b1;
        end
        if (lv_q) begin
          g_rd_en   = 1'b1;
          g_rd_addr = {list_rdata_q, pa_q};
          gv_d      = 1'b1;
        end
        if (gv_q && g_rd_data.granted) begin
          if (has_lvl_q) begin
            if (!g_rd_data.unleveled && (g_rd_data.level >= lvl_q)) begin
              best_d  = rpc_pkg::VERDICT_TRUE;
              state_d = rpc_pkg::ST_Q_DONE;
            end
          end else if (!p_lev) begin
            best_d  = rpc_pkg::VERDICT_TRUE;
            state_d = rpc_pkg::ST_Q_DONE;
          end else if (g_rd_data.unleveled) begin
            if (best_q == rpc_pkg::VERDICT_FALSE) begin
              best_d = rpc_pkg::VERDICT_TRUE;
            end
          end else if ((best_q != rpc_pkg::VERDICT_LEVEL) ||
                       (g_rd_data.level > best_lvl_q)) begin
            best_d     = rpc_pkg::VERDICT_LEVEL;
            best_lvl_d = g_rd_data.level;
          end
        end
        if ((k_q == cnt_rdata_q) && !lv_q && !gv_q) begin
          state_d = rpc_pkg::ST_Q_DONE;
        end
        // Early exit drops reads still in flight
        if (state_d == rpc_pkg::ST_Q_DONE) begin
          lv_d = 1'b0;
          gv_d = 1'b0;
        end
      end

      rpc_pkg::ST_Q_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rpc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rpc_pkg::ST_CLEAR;
      clr_q      <= '0;
      k_q        <= '0;
      lv_q       <= 1'b0;
      gv_q       <= 1'b0;
      best_q     <= rpc_pkg::VERDICT_FALSE;
      best_lvl_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      k_q        <= k_d;
      lv_q       <= lv_d;
      gv_q       <= gv_d;
      best_q     <= best_d;
      best_lvl_q <= best_lvl_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= best_q;
      lvl_out_q <= (best_q == rpc_pkg::VERDICT_LEVEL) ? best_lvl_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign level_out_o = lvl_out_q;

endmodule

### rtl/rpc_checker.sv
`timescale 1ns / 1ps

// Port-level checks for the permission checker
module rpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [rpc_pkg::CMD_W-1:0]     cmd_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rpc_pkg::VERDICT_W-1:0] verdict_o,
  input logic [rpc_pkg::LEVEL_W-1:0]   level_out_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) && $stable(level_out_o))
    else $error("stalled result changed");

  // Level is reported only with the level verdict
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o != rpc_pkg::VERDICT_LEVEL) |-> level_out_o == '0)
    else $error("level_out nonzero without level verdict");

  // A query always keeps the block busy in the cycle after it is accepted
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == rpc_pkg::CMD_QUERY) |=> in_stall_o)
    else $error("query accepted without a busy cycle");

  // A new result only follows query processing
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without query processing");

  // The grant table sweep keeps the input stalled right after reset
  a_clear_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open during clearing sweep");

endmodule

bind role_permission_check rpc_checker u_rpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o),
  .level_out_o (level_out_o)
);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rpc_pkg::*;

  localparam int NPRIVS       = MAX_PRIVS_DEF;
  localparam int NROLES       = MAX_ROLES_DEF;
  localparam int NUSERS       = MAX_USERS_DEF;
  localparam int RPU          = ROLES_PER_USER_DEF;
  // Room for the reset sweep of the grant table plus the traffic
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    verdict_e           verdict;
    logic [LEVEL_W-1:0] level;
  } answer_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [ID_W-1:0]      user_id_i;
  logic [ID_W-1:0]      role_id_i;
  logic [ID_W-1:0]      priv_id_i;
  logic [LEVEL_W-1:0]   level_i;
  logic                 has_level_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [VERDICT_W-1:0] verdict_o;
  logic [LEVEL_W-1:0]   level_out_o;

  // Shadow copy of the access tables
  bit                   priv_declared [NPRIVS];
  bit                   priv_leveled  [NPRIVS];
  grant_t               grant_tab     [NROLES][NPRIVS];
  int                   role_cnt      [NUSERS];
  logic [ID_W-1:0]      role_list     [NUSERS][RPU];

  answer_t              expected_answers [$];
  int                   fail_cnt = 0;
  int                   cycle_cnt;
  bit                   tx_idle_en = 1'b0;
  bit                   rx_idle_en = 1'b0;
  int                   rx_hold_cycles = 0;

  role_permission_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .user_id_i   (user_id_i),
    .role_id_i   (role_id_i),
    .priv_id_i   (priv_id_i),
    .level_i     (level_i),
    .has_level_i (has_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o),
    .level_out_o (level_out_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Answer of a query against the shadow tables, roles scanned in list order
  function automatic answer_t predict_answer(input logic [ID_W-1:0] uid,
                                             input logic [ID_W-1:0] pid,
                                             input logic [LEVEL_W-1:0] lv,
                                             input logic has_lvl);
    int      best;
    int      v;
    grant_t  g;
    answer_t a;
    best      = -2;  // -2 nothing held, -1 true, 0..9 highest level
    a.verdict = VERDICT_FALSE;
    a.level   = '0;
    if (uid < NUSERS && pid < NPRIVS && priv_declared[pid]) begin
      for (int k = 0; k < role_cnt[uid]; k++) begin
        g = grant_tab[role_list[uid][k]][pid];
        if (g.granted) begin
          if (has_lvl) begin
            // unleveled grants never satisfy a leveled query
            if (!g.unleveled && g.level >= lv) begin
              best = -1;
              break;
            end
          end else if (!priv_leveled[pid]) begin
            best = -1;
            break;
          end else begin
            v = g.unleveled ? -1 : int'(g.level);
            if (v > best) best = v;
          end
        end
      end
    end
    if (best == -1) begin
      a.verdict = VERDICT_TRUE;
    end else if (best >= 0) begin
      a.verdict = VERDICT_LEVEL;
      a.level   = LEVEL_W'(best);
    end
    return a;
  endfunction

  // Apply one accepted command to the shadow tables; queries queue an answer
  function automatic void update_access_tables(input cmd_e cmd,
                                               input logic [ID_W-1:0] uid,
                                               input logic [ID_W-1:0] rid,
                                               input logic [ID_W-1:0] pid,
                                               input logic [LEVEL_W-1:0] lvl,
                                               input logic has_lvl);
    logic [LEVEL_W-1:0] lv;
    grant_t             cur;
    lv = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    case (cmd)
      CMD_DECLARE: begin
        if (pid < NPRIVS) begin
          priv_declared[pid] = 1'b1;
          priv_leveled[pid]  = has_lvl;
        end
      end
      CMD_GRANT: begin
        if (rid < NROLES && pid < NPRIVS && priv_declared[pid]) begin
          cur = grant_tab[rid][pid];
          if (!has_lvl) begin
            cur.granted   = 1'b1;
            cur.unleveled = 1'b1;
            cur.level     = '0;
          end else if (!cur.granted || cur.unleveled || lv > cur.level) begin
            cur.granted   = 1'b1;
            cur.unleveled = 1'b0;
            cur.level     = lv;
          end
          grant_tab[rid][pid] = cur;
        end
      end
      CMD_ADD_ROLE: begin
        // a full list drops the new role
        if (uid < NUSERS && rid < NROLES && role_cnt[uid] < RPU) begin
          role_list[uid][role_cnt[uid]] = rid;
          role_cnt[uid]++;
        end
      end
      CMD_QUERY: expected_answers.insert(expected_answers.size(),
                                         predict_answer(uid, pid, lv, has_lvl));
      default: ;
    endcase
  endfunction

  // Offer one transaction, hold it until accepted, then track it
  task automatic send_command(input cmd_e cmd, input logic [ID_W-1:0] uid,
                              input logic [ID_W-1:0] rid, input logic [ID_W-1:0] pid,
                              input logic [LEVEL_W-1:0] lvl, input logic has_lvl);
    while (tx_idle_en && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    user_id_i   <= uid;
    role_id_i   <= rid;
    priv_id_i   <= pid;
    level_i     <= lvl;
    has_level_i <= has_lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    update_access_tables(cmd, uid, rid, pid, lvl, has_lvl);
  endtask

  // Mostly small id pools so grants, role lists and queries meet; some full-range noise
  task automatic send_random_command();
    cmd_e               c;
    logic [ID_W-1:0]    u;
    logic [ID_W-1:0]    r;
    logic [ID_W-1:0]    p;
    logic [LEVEL_W-1:0] l;
    logic               h;
    int                 roll;
    roll = $urandom_range(99);
    if (roll < 10) c = CMD_DECLARE;
    else if (roll < 38) c = CMD_GRANT;
    else if (roll < 58) c = CMD_ADD_ROLE;
    else c = CMD_QUERY;
    if ($urandom_range(9) == 0) begin
      u = ID_W'($urandom);
      r = ID_W'($urandom);
      p = ID_W'($urandom);
    end else begin
      u = ID_W'($urandom_range(5));
      r = ID_W'($urandom_range(11));
      p = ID_W'($urandom_range(9));
    end
    l = ($urandom_range(3) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(9));
    h = 1'($urandom);
    send_command(c, u, r, p, l, h);
  endtask

  // Boundary ids, level saturation, overwrite rules and the empty cases
  task automatic test_directed_cases();
    send_command(CMD_QUERY,    7'd0,   7'd0,   7'd0,   4'd0,  1'b0);  // undeclared
    send_command(CMD_DECLARE,  7'd0,   7'd0,   7'd127, 4'd15, 1'b1);
    send_command(CMD_DECLARE,  7'd127, 7'd127, 7'd0,   4'd0,  1'b0);
    send_command(CMD_GRANT,    7'd0,   7'd127, 7'd127, 4'd15, 1'b1);  // saturates to 9
    send_command(CMD_GRANT,    7'd0,   7'd127, 7'd127, 4'd3,  1'b1);  // lower level kept out
    send_command(CMD_GRANT,    7'd0,   7'd0,   7'd1,   4'd5,  1'b1);  // undeclared, ignored
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd0,  1'b1);  // user has no roles
    send_command(CMD_ADD_ROLE, 7'd127, 7'd127, 7'd0,   4'd0,  1'b0);
    send_command(CMD_ADD_ROLE, 7'd127, 7'd0,   7'd0,   4'd0,  1'b0);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd15, 1'b1);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd0,  1'b0);
    send_command(CMD_GRANT,    7'd0,   7'd0,   7'd0,   4'd0,  1'b0);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd0,   4'd0,  1'b0);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd0,   4'd0,  1'b1);  // unleveled never meets a level
    send_command(CMD_GRANT,    7'd0,   7'd127, 7'd127, 4'd7,  1'b0);  // overwrite as unleveled
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd0,  1'b0);
    send_command(CMD_GRANT,    7'd0,   7'd0,   7'd127, 4'd4,  1'b1);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd0,  1'b0);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd5,  1'b1);
    send_command(CMD_DECLARE,  7'd0,   7'd0,   7'd127, 4'd0,  1'b0);  // redeclare unleveled
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd127, 4'd0,  1'b0);
    send_command(CMD_QUERY,    7'd127, 7'd0,   7'd1,   4'd0,  1'b0);
  endtask

  task automatic test_random_traffic(input int n_items);
    repeat (n_items) send_random_command();
  endtask

  // Receiver holds off for a long stretch while commands keep coming
  task automatic test_backpressure();
    rx_hold_cycles = HOLD_CYCLES;
    repeat (40) send_random_command();
  endtask

  // Receiver stall: random idling, or a counted hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_stall_i    <= 1'b1;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
        out_stall_i <= rx_idle_en && ($urandom_range(99) < 23);
      end
    end
  end

  // Result checker: each transaction against the oldest expected answer
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result, verdict %0d level %0d", $time,
                 verdict_o, level_out_o);
        fail_cnt++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (verdict_o !== exp_ans.verdict) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
                   exp_ans.verdict, verdict_o);
          fail_cnt++;
        end
        if (level_out_o !== exp_ans.level) begin
          $display("%0t: level mismatch, expected %0d, actual %0d", $time,
                   exp_ans.level, level_out_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_DECLARE;
    user_id_i   = '0;
    role_id_i   = '0;
    priv_id_i   = '0;
    level_i     = '0;
    has_level_i = 1'b0;
    for (int r = 0; r < NROLES; r++)
      for (int p = 0; p < NPRIVS; p++) grant_tab[r][p] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_traffic(200);
    // stretch with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(100);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_backpressure();
    test_random_traffic(150);

    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
